// ----- design/glu_pkg.sv -----
// ----------------------------------------------------------------------------
// glu_pkg
// shared constants, types and state encoding for the gcd / lcm unit
// ----------------------------------------------------------------------------
package glu_pkg;

    // number of low operand bits that take part (8 to 32)
    localparam int OP_W  = 32;
    localparam int CNT_W = $clog2(OP_W + 1);

    // port widths fixed by the interface
    localparam int IN_W  = 32;
    localparam int GCD_W = 32;
    localparam int LCM_W = 64;

    typedef logic [OP_W-1:0] t_op;

    // request to the shared divider
    typedef struct packed {
        logic start;
        t_op  dividend;
        t_op  divisor;
    } t_div_req;

    // response from the shared divider
    typedef struct packed {
        logic done;
        t_op  quotient;
        t_op  remainder;
    } t_div_rsp;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_GCD,
        ST_QUO,
        ST_MUL,
        ST_DONE
    } t_state;

endpackage

// ----- design/glu_divider.sv -----
// ----------------------------------------------------------------------------
// glu_divider
// shared restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module glu_divider (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  glu_pkg::t_div_req i_req,
    output glu_pkg::t_div_rsp o_rsp
);
    import glu_pkg::*;

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    t_op              r_q;
    t_op              r_rem;
    t_op              r_div;

    logic [OP_W:0]    rem_sh;
    logic [OP_W:0]    diff;
    logic             q_bit;

    always_comb begin
        rem_sh = {r_rem, r_q[OP_W-1]};
        diff   = rem_sh - {1'b0, r_div};
        q_bit  = ~diff[OP_W];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(OP_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // datapath, no reset needed
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_q   <= i_req.dividend;
            r_rem <= '0;
            r_div <= i_req.divisor;
        end else if (r_busy) begin
            r_q   <= {r_q[OP_W-2:0], q_bit};
            r_rem <= q_bit ? diff[OP_W-1:0] : rem_sh[OP_W-1:0];
        end
    end

    assign o_rsp.done      = r_done;
    assign o_rsp.quotient  = r_q;
    assign o_rsp.remainder = r_rem;

endmodule

// ----- design/gcd_lcm_unit.sv -----
// ----------------------------------------------------------------------------
// gcd_lcm_unit
// greatest common divisor and least common multiple of two unsigned operands.
// one item is taken at a time. each Euclid remainder step runs through the
// single shared restoring divider; after the gcd is found the same divider
// forms a / gcd, then one registered 32 x 32 multiply gives the lcm. a zero
// operand skips all of it and returns with zero_error set and both results
// zero. operand bits above the low OP_W are ignored. the result sits in an
// output register, so the next item is taken while an earlier result still
// waits for its transfer.
// ----------------------------------------------------------------------------
module gcd_lcm_unit (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    // input channel
    input  logic                      i_in_valid,
    output logic                      o_in_stall,
    input  logic [glu_pkg::IN_W-1:0]  i_operand_a,
    input  logic [glu_pkg::IN_W-1:0]  i_operand_b,
    // result channel
    output logic                      o_out_valid,
    input  logic                      i_out_stall,
    output logic [glu_pkg::GCD_W-1:0] o_gcd_value,
    output logic [glu_pkg::LCM_W-1:0] o_lcm_value,
    output logic                      o_zero_error
);
    import glu_pkg::*;

    // sequencer state and working registers
    t_state                r_state, n_state;
    t_op                   r_a, n_a;       // masked operand a, kept for a / gcd
    t_op                   r_b, n_b;       // masked operand b, kept for the multiply
    t_op                   r_y, n_y;       // current Euclid divisor
    t_op                   r_gcd, n_gcd;
    t_op                   r_q, n_q;       // a / gcd
    logic [2*OP_W-1:0]     r_lcm, n_lcm;
    logic                  r_err, n_err;
    t_div_req              r_req, n_req;

    // output register
    logic                  r_out_valid, n_out_valid;
    logic [GCD_W-1:0]      r_out_gcd, n_out_gcd;
    logic [LCM_W-1:0]      r_out_lcm, n_out_lcm;
    logic                  r_out_err, n_out_err;

    t_div_rsp              div_rsp;
    t_op                   in_a, in_b;
    logic                  in_xfer;
    logic                  out_free;

    glu_divider u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (r_req),
        .o_rsp  (div_rsp)
    );

    // only the low OP_W bits of each operand take part
    assign in_a       = i_operand_a[OP_W-1:0];
    assign in_b       = i_operand_b[OP_W-1:0];
    assign o_in_stall = (r_state != ST_IDLE);
    assign in_xfer    = i_in_valid && !o_in_stall;
    // output register can take a new result when empty or being drained
    assign out_free   = !r_out_valid || !i_out_stall;

    always_comb begin
        n_state     = r_state;
        n_a         = r_a;
        n_b         = r_b;
        n_y         = r_y;
        n_gcd       = r_gcd;
        n_q         = r_q;
        n_lcm       = r_lcm;
        n_err       = r_err;
        n_req       = r_req;
        n_req.start = 1'b0;
        n_out_valid = r_out_valid && i_out_stall;
        n_out_gcd   = r_out_gcd;
        n_out_lcm   = r_out_lcm;
        n_out_err   = r_out_err;

        case (r_state)
            ST_IDLE: begin
                if (in_xfer) begin
                    n_a = in_a;
                    n_b = in_b;
                    if (in_a == '0 || in_b == '0) begin
                        // zero operand: flag and skip the arithmetic
                        n_err   = 1'b1;
                        n_gcd   = '0;
                        n_lcm   = '0;
                        n_state = ST_DONE;
                    end else begin
                        n_err        = 1'b0;
                        n_y          = in_b;
                        n_req.start  = 1'b1;
                        n_req.dividend = in_a;
                        n_req.divisor  = in_b;
                        n_state      = ST_GCD;
                    end
                end
            end
            ST_GCD: begin
                if (div_rsp.done) begin
                    if (div_rsp.remainder == '0) begin
                        // divisor of the last step is the gcd, now form a / gcd
                        n_gcd          = r_y;
                        n_req.start    = 1'b1;
                        n_req.dividend = r_a;
                        n_req.divisor  = r_y;
                        n_state        = ST_QUO;
                    end else begin
                        // shift the pair and divide again
                        n_y            = div_rsp.remainder;
                        n_req.start    = 1'b1;
                        n_req.dividend = r_y;
                        n_req.divisor  = div_rsp.remainder;
                    end
                end
            end
            ST_QUO: begin
                if (div_rsp.done) begin
                    n_q     = div_rsp.quotient;
                    n_state = ST_MUL;
                end
            end
            ST_MUL: begin
                // (a / gcd) * b, cannot exceed 2 * OP_W bits
                n_lcm   = (2*OP_W)'(r_q) * (2*OP_W)'(r_b);
                n_state = ST_DONE;
            end
            ST_DONE: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_gcd   = GCD_W'(r_gcd);
                    n_out_lcm   = LCM_W'(r_lcm);
                    n_out_err   = r_err;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_req.start <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_req.start <= n_req.start;
            r_out_valid <= n_out_valid;
        end
    end

    // payload, no reset needed
    always_ff @(posedge i_clk) begin
        r_a            <= n_a;
        r_b            <= n_b;
        r_y            <= n_y;
        r_gcd          <= n_gcd;
        r_q            <= n_q;
        r_lcm          <= n_lcm;
        r_err          <= n_err;
        r_req.dividend <= n_req.dividend;
        r_req.divisor  <= n_req.divisor;
        r_out_gcd      <= n_out_gcd;
        r_out_lcm      <= n_out_lcm;
        r_out_err      <= n_out_err;
    end

    assign o_out_valid  = r_out_valid;
    assign o_gcd_value  = r_out_gcd;
    assign o_lcm_value  = r_out_lcm;
    assign o_zero_error = r_out_err;

    // an errored result carries zeros in both result fields
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_zero_error) |-> (o_gcd_value == '0 && o_lcm_value == '0))
        else $error("zero_error result with non-zero value");

    // a good result always has a non-zero gcd
    a_gcd_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_zero_error) |-> (o_gcd_value != '0))
        else $error("zero gcd on a good result");

    // the divider only reports while the sequencer waits for it
    a_div_owner: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_rsp.done |-> (r_state == ST_GCD || r_state == ST_QUO))
        else $error("divider done outside a divide state");

    // a transfer in closes the input until the result is moved to the output register
    a_busy_after_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_xfer |=> o_in_stall)
        else $error("input open right after a transfer");

endmodule

// ----- tb/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench
// checks gcd_lcm_unit against an in-bench model of Euclid's gcd and the
// double-width lcm. a short table of directed pairs comes first, then about
// 1200 random pairs of several kinds: zero operands, equal operands, pairs
// with a large common factor, small values, consecutive Fibonacci numbers
// and plain random words. both channels idle in random bursts except in the
// closing stretch of the run.
// ----------------------------------------------------------------------------
module testbench;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int IN_W  = glu_pkg::IN_W;
    localparam int GCD_W = glu_pkg::GCD_W;
    localparam int LCM_W = glu_pkg::LCM_W;
    localparam int OP_W  = glu_pkg::OP_W;

    localparam int RANDOM_PAIRS = 1200;
    localparam int QUIET_PAIRS  = 100;   // closing stretch with no idling
    // slowest pair is the Fibonacci worst case, about 47 divider passes;
    // add both sides' longest burst and take it four times
    localparam longint CYCLE_LIMIT = 64'd9_000_000;
    localparam int SETTLE_CYCLES   = 200;

    // one result as it leaves the block
    typedef struct packed {
        logic [GCD_W-1:0] gcd;
        logic [LCM_W-1:0] lcm;
        logic             zero_err;
    } t_gcd_lcm;

    // directed row; pinned rows carry their result, the rest use the model
    typedef struct packed {
        logic [IN_W-1:0] a;
        logic [IN_W-1:0] b;
        logic            pinned;
        t_gcd_lcm        want;
    } t_pair_row;

    localparam int DIRECTED_ROWS = 21;
    localparam t_pair_row DIRECTED [0:DIRECTED_ROWS-1] = '{
        // zero operands, on either side and both
        '{32'h0000_0000, 32'h0000_0000, 1'b1, '{32'd0, 64'd0, 1'b1}},
        '{32'h0000_0000, 32'h0000_0007, 1'b1, '{32'd0, 64'd0, 1'b1}},
        '{32'h0000_0007, 32'h0000_0000, 1'b1, '{32'd0, 64'd0, 1'b1}},
        '{32'h0000_0000, 32'hFFFF_FFFF, 1'b1, '{32'd0, 64'd0, 1'b1}},
        '{32'hFFFF_FFFF, 32'h0000_0000, 1'b1, '{32'd0, 64'd0, 1'b1}},
        // ones and all-ones
        '{32'h0000_0001, 32'h0000_0001, 1'b1, '{32'd1, 64'd1, 1'b0}},
        '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1,
          '{32'hFFFF_FFFF, 64'h0000_0000_FFFF_FFFF, 1'b0}},
        '{32'h0000_0001, 32'hFFFF_FFFF, 1'b1, '{32'd1, 64'h0000_0000_FFFF_FFFF, 1'b0}},
        '{32'hFFFF_FFFF, 32'h0000_0001, 1'b1, '{32'd1, 64'h0000_0000_FFFF_FFFF, 1'b0}},
        // largest lcm that fits the port
        '{32'hFFFF_FFFF, 32'hFFFF_FFFE, 1'b1, '{32'd1, 64'hFFFF_FFFD_0000_0002, 1'b0}},
        '{32'd12,        32'd18,        1'b1, '{32'd6, 64'd36, 1'b0}},
        '{32'h8000_0000, 32'h4000_0000, 1'b1,
          '{32'h4000_0000, 64'h0000_0000_8000_0000, 1'b0}},
        '{32'h0000_0001, 32'h8000_0000, 1'b1, '{32'd1, 64'h0000_0000_8000_0000, 1'b0}},
        '{32'h0000_0002, 32'h0000_0001, 1'b1, '{32'd1, 64'd2, 1'b0}},
        // equal operands
        '{32'd12345,     32'd12345,     1'b1, '{32'd12345, 64'd12345, 1'b0}},
        // longest Euclid chain: consecutive Fibonacci numbers, both orders
        '{32'hB119_24E1, 32'h6D73_E55F, 1'b0, '0},
        '{32'h6D73_E55F, 32'hB119_24E1, 1'b0, '0},
        // two large primes
        '{32'hFFFF_FFFB, 32'hFFFF_FFEF, 1'b0, '0},
        '{32'hAAAA_AAAA, 32'h5555_5555, 1'b0, '0},
        '{32'hFFFF_0000, 32'h0000_FFFF, 1'b0, '0},
        '{32'h0001_0000, 32'hFFFF_FFFF, 1'b0, '0}
    };

    logic             i_clk       = 1'b0;
    logic             i_rst_n     = 1'b0;
    logic             i_in_valid  = 1'b0;
    logic [IN_W-1:0]  i_operand_a = '0;
    logic [IN_W-1:0]  i_operand_b = '0;
    logic             i_out_stall = 1'b0;
    logic             o_in_stall;
    logic             o_out_valid;
    logic [GCD_W-1:0] o_gcd_value;
    logic [LCM_W-1:0] o_lcm_value;
    logic             o_zero_error;

    t_gcd_lcm gcd_lcm_owed [$];   // results still to come, oldest first
    int       mismatches  = 0;
    longint   cycle_count = 0;
    bit       quiet_tail  = 1'b0; // no idling on either side once set
    int       gap_pct     = 25;   // chance of a send gap before a pair
    int       stall_pct   = 40;   // chance of a stall burst on the result side

    gcd_lcm_unit dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_operand_a  (i_operand_a),
        .i_operand_b  (i_operand_b),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_gcd_value  (o_gcd_value),
        .o_lcm_value  (o_lcm_value),
        .o_zero_error (o_zero_error)
    );

    always #5 i_clk = ~i_clk;

    // gcd by repeated remainder, lcm as (a / gcd) * b at full width
    function automatic t_gcd_lcm gcd_lcm_of(input logic [IN_W-1:0] a_in,
                                            input logic [IN_W-1:0] b_in);
        logic [OP_W-1:0]  a_op;
        logic [OP_W-1:0]  b_op;
        logic [OP_W-1:0]  hi;
        logic [OP_W-1:0]  lo;
        logic [OP_W-1:0]  rem;
        logic [LCM_W-1:0] quo_w;
        logic [LCM_W-1:0] b_w;
        t_gcd_lcm         res;
        // only the low OP_W bits take part
        a_op = a_in[OP_W-1:0];
        b_op = b_in[OP_W-1:0];
        res  = '0;
        if (a_op == '0 || b_op == '0) begin
            res.zero_err = 1'b1;
        end else begin
            hi  = a_op;
            lo  = b_op;
            rem = hi % lo;
            while (rem != '0) begin
                hi  = lo;
                lo  = rem;
                rem = hi % lo;
            end
            quo_w   = '0;
            b_w     = '0;
            quo_w[OP_W-1:0] = a_op / lo;
            b_w[OP_W-1:0]   = b_op;
            res.gcd = '0;
            res.gcd[OP_W-1:0] = lo;
            res.lcm = quo_w * b_w;
        end
        return res;
    endfunction

    // present one pair, hold it until the transfer, then log what it owes
    task automatic send_pair(input logic [IN_W-1:0] a, input logic [IN_W-1:0] b,
                             input t_gcd_lcm want);
        if (!quiet_tail && $urandom_range(0, 99) < gap_pct) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_operand_a <= a;
        i_operand_b <= b;
        do @(posedge i_clk); while (o_in_stall);
        gcd_lcm_owed.push_back(want);
    endtask

    // stimulus
    initial begin
        logic [IN_W-1:0] a;
        logic [IN_W-1:0] b;
        logic [IN_W-1:0] fib_lo;
        logic [IN_W-1:0] fib_hi;
        logic [IN_W-1:0] fib_sum;
        logic [IN_W-1:0] factor;
        int              pick;

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (DIRECTED[i]) begin
            if (DIRECTED[i].pinned)
                send_pair(DIRECTED[i].a, DIRECTED[i].b, DIRECTED[i].want);
            else
                send_pair(DIRECTED[i].a, DIRECTED[i].b,
                          gcd_lcm_of(DIRECTED[i].a, DIRECTED[i].b));
        end

        for (int n = 0; n < RANDOM_PAIRS; n++) begin
            // change the idling mix every hundred pairs, including none at all
            if (n % 100 == 0) begin
                case ($urandom_range(0, 2))
                    0: begin gap_pct = 0;  stall_pct = 0;  end
                    1: begin gap_pct = 20; stall_pct = 40; end
                    default: begin gap_pct = 50; stall_pct = 80; end
                endcase
            end
            if (n >= RANDOM_PAIRS - QUIET_PAIRS)
                quiet_tail = 1'b1;

            pick = $urandom_range(0, 99);
            if (pick < 6) begin
                // zero on one side or both
                a = $urandom_range(0, 1) ? '0 : $urandom();
                b = (a != '0 || $urandom_range(0, 1)) ? '0 : $urandom();
            end else if (pick < 14) begin
                // equal operands
                a = $urandom() >> $urandom_range(0, 31);
                b = a;
            end else if (pick < 34) begin
                // shared factor, so a large gcd
                factor = $urandom_range(1, 65535);
                a = factor * $urandom_range(1, 65535);
                b = factor * $urandom_range(1, 65535);
            end else if (pick < 44) begin
                // small values
                a = $urandom_range(1, 255);
                b = $urandom_range(1, 255);
            end else if (pick < 47) begin
                // consecutive Fibonacci numbers, a long remainder chain
                fib_lo = 1;
                fib_hi = 1;
                repeat ($urandom_range(10, 45)) begin
                    fib_sum = fib_lo + fib_hi;
                    fib_lo  = fib_hi;
                    fib_hi  = fib_sum;
                end
                a = $urandom_range(0, 1) ? fib_hi : fib_lo;
                b = (a == fib_hi) ? fib_lo : fib_hi;
            end else if (pick < 72) begin
                // random words of random length
                a = $urandom() >> $urandom_range(0, 31);
                b = $urandom() >> $urandom_range(0, 31);
            end else begin
                // full random words
                a = $urandom();
                b = $urandom();
            end
            send_pair(a, b, gcd_lcm_of(a, b));
        end
        i_in_valid <= 1'b0;

        // drain, then leave room for any stray result
        while (gcd_lcm_owed.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        if (mismatches == 0 && gcd_lcm_owed.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    // result side: stall bursts between free stretches
    initial begin
        @(posedge i_rst_n);
        forever begin
            if (!quiet_tail && $urandom_range(0, 99) < stall_pct) begin
                i_out_stall <= 1'b1;
                repeat ($urandom_range(1, 13)) @(posedge i_clk);
            end
            i_out_stall <= 1'b0;
            repeat ($urandom_range(1, 30)) @(posedge i_clk);
        end
    end

    // compare every result transfer with the oldest owed result
    always @(posedge i_clk) begin
        t_gcd_lcm want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (gcd_lcm_owed.size() == 0) begin
                $error("result transfer with nothing owed: gcd %h lcm %h zero_error %b",
                       o_gcd_value, o_lcm_value, o_zero_error);
                mismatches++;
            end else begin
                want = gcd_lcm_owed.pop_front();
                if (o_gcd_value !== want.gcd) begin
                    $error("gcd_value: expected %h, got %h", want.gcd, o_gcd_value);
                    mismatches++;
                end
                if (o_lcm_value !== want.lcm) begin
                    $error("lcm_value: expected %h, got %h", want.lcm, o_lcm_value);
                    mismatches++;
                end
                if (o_zero_error !== want.zero_err) begin
                    $error("zero_error: expected %b, got %b", want.zero_err, o_zero_error);
                    mismatches++;
                end
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

endmodule
